// File: sv/tvaf_pkg.sv
// Shared types, constants and character helpers for the ASCII formatter.
package tvaf_pkg;

  localparam int unsigned CMD_W  = 4;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NDIG   = 20;
  localparam int unsigned DIG_IW = 5;
  localparam int unsigned BCD_W  = NDIG * 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_NULL  = 4'd0,
    CMD_BOOL  = 4'd1,
    CMD_INT   = 4'd2,
    CMD_HEX   = 4'd3,
    CMD_FLOAT = 4'd4,
    CMD_CHAR  = 4'd5,
    CMD_DELIM = 4'd6,
    CMD_FLUSH = 4'd7,
    CMD_RAW   = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    T_IDLE, T_FLT, T_BCD, T_PRE, T_DIG, T_TXT
  } top_state_e;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL_A, F_MUL_B, F_ROUND, F_SHIFT, F_DONE
  } flt_state_e;

  typedef struct packed {
    logic done;
    logic neg;
  } flt_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bcd_stat_t;

  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_X     = 8'h78;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0a;
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;

  function automatic logic [CH_W-1:0] digit_char(input logic [3:0] d);
    logic [CH_W-1:0] r;
    if (d < 4'd10) r = CH_0 + {4'b0000, d};
    else           r = CH_LA + {4'b0000, d} - 8'd10;
    return r;
  endfunction

  // Index of the final byte of a fixed-text command.
  function automatic logic [2:0] txt_last(input cmd_e c, input logic flag);
    logic [2:0] r;
    unique case (c)
      CMD_NULL:  r = 3'd3;
      CMD_BOOL:  r = flag ? 3'd3 : 3'd4;
      CMD_FLUSH: r = 3'd1;
      CMD_RAW:   r = 3'd7;
      default:   r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CH_W-1:0] txt_char(input cmd_e c, input logic flag,
                                               input logic [2:0] i,
                                               input logic [VAL_W-1:0] v);
    logic [CH_W-1:0] r;
    r = CH_NUL;
    unique case (c)
      CMD_NULL: begin
        unique case (i)
          3'd0:    r = 8'h6e;
          3'd1:    r = 8'h75;
          default: r = 8'h6c;
        endcase
      end
      CMD_BOOL: begin
        if (flag) begin
          unique case (i)
            3'd0:    r = 8'h74;
            3'd1:    r = 8'h72;
            3'd2:    r = 8'h75;
            default: r = 8'h65;
          endcase
        end else begin
          unique case (i)
            3'd0:    r = 8'h66;
            3'd1:    r = 8'h61;
            3'd2:    r = 8'h6c;
            3'd3:    r = 8'h73;
            default: r = 8'h65;
          endcase
        end
      end
      CMD_CHAR:  r = v[CH_W-1:0];
      CMD_DELIM: r = CH_COMMA;
      CMD_FLUSH: r = (i == 3'd0) ? CH_NL : CH_NUL;
      CMD_RAW:   r = v[{i, 3'b000} +: CH_W];
      default:   r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

// File: sv/tvaf_if.sv
// Valid/ready channel interfaces for formatter commands and output bytes.
interface tvaf_in_if;
  import tvaf_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [VAL_W-1:0] value;
  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface tvaf_out_if;
  import tvaf_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;
  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// File: sv/tvaf_flt.sv
// Double to scaled integer unit: times 1000, round, truncate, saturate.
module tvaf_flt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tvaf_pkg::VAL_W-1:0] bits_i,
  output logic [tvaf_pkg::VAL_W-1:0] mag_o,
  output tvaf_pkg::flt_stat_t        stat_o
);
  import tvaf_pkg::*;

  flt_state_e        state_q, state_d;
  logic [52:0]       m_q;
  logic [62:0]       prod_q;
  logic [10:0]       expf_q;
  logic              sign_q;
  logic [VAL_W-1:0]  mag_q;
  logic [5:0]        cnt_q;
  logic              left_q;

  logic              is_nan, is_inf, is_zero;
  logic              hi, g, st;
  logic [52:0]       keep;
  logic [53:0]       rnd;
  logic signed [12:0] k, kn;
  logic              sat, tiny;

  assign is_nan  = (bits_i[62:52] == 11'h7ff) && (bits_i[51:0] != '0);
  assign is_inf  = (bits_i[62:52] == 11'h7ff) && (bits_i[51:0] == '0);
  assign is_zero = (bits_i[62:52] == 11'h000);

  // Product lies in [2^61, 2^63): keep 53 bits from the leading one down.
  always_comb begin
    hi   = prod_q[62];
    keep = hi ? prod_q[62:10] : prod_q[61:9];
    g    = hi ? prod_q[9] : prod_q[8];
    st   = hi ? (|prod_q[8:0]) : (|prod_q[7:0]);
    rnd  = {1'b0, keep} + {53'd0, g & (st | keep[0])};
    k    = $signed({2'b00, expf_q}) - 13'sd1075 + (hi ? 13'sd10 : 13'sd9);
    kn   = -k;
    sat  = (k > 13'sd10) || ((k == 13'sd10) && rnd[53]);
    tiny = (k < -13'sd53);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          if (is_nan || is_inf || is_zero) state_d = F_DONE;
          else                             state_d = F_MUL_A;
        end
      end
      F_MUL_A: state_d = F_MUL_B;
      F_MUL_B: state_d = F_ROUND;
      F_ROUND: state_d = (sat || tiny) ? F_DONE : F_SHIFT;
      F_SHIFT: if (cnt_q == 6'd0) state_d = F_DONE;
      F_DONE:  state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    stat_o.done = (state_q == F_DONE);
    stat_o.neg  = sign_q & (|mag_q);
  end
  assign mag_o = mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= F_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          m_q    <= {1'b1, bits_i[51:0]};
          expf_q <= bits_i[62:52];
          sign_q <= bits_i[63] & ~is_nan;
          if (is_inf) mag_q <= bits_i[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          else        mag_q <= '0;
        end
      end
      // 1000 = 1024 - 16 - 8, taken as two subtractions.
      F_MUL_A: prod_q <= {m_q, 10'd0} - {6'd0, m_q, 4'd0};
      F_MUL_B: prod_q <= prod_q - {7'd0, m_q, 3'd0};
      F_ROUND: begin
        if (sat)       mag_q <= sign_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else if (tiny) mag_q <= '0;
        else           mag_q <= {10'd0, rnd};
        left_q <= ~k[12];
        cnt_q  <= k[12] ? kn[5:0] : k[5:0];
      end
      F_SHIFT: begin
        if (cnt_q != 6'd0) begin
          mag_q <= left_q ? {mag_q[VAL_W-2:0], 1'b0} : {1'b0, mag_q[VAL_W-1:1]};
          cnt_q <= cnt_q - 6'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/tvaf_bcd.sv
// Bit-serial binary to BCD converter (shift and add three).
module tvaf_bcd (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tvaf_pkg::VAL_W-1:0]  value_i,
  input  logic [tvaf_pkg::DIG_IW-1:0] sel_i,
  output logic [3:0]                  dig_o,
  output tvaf_pkg::bcd_stat_t         stat_o
);
  import tvaf_pkg::*;

  logic [VAL_W-1:0] sh_q;
  logic [BCD_W-1:0] bcd_q, adj;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                : bcd_q[i*4 +: 4];
    end
  end

  assign dig_o       = bcd_q[{sel_i, 2'b00} +: 4];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[VAL_W-2:0], 1'b0};
      bcd_q <= {adj[BCD_W-2:0], sh_q[VAL_W-1]};
    end
  end

endmodule

// File: sv/typed_value_to_ascii_formatter.sv
// Text commands load their bytes from the text state once the item is taken; hex loads
// "0x" and then its digits. Int runs the serial binary-to-BCD converter before its first byte
// is loaded. Float: the scaling unit first (one bit of alignment a cycle), then the int path.
// Leading zero digits are skipped without output, then one byte per cycle while the output is
// not stalled; one item is in flight at a time, and the next is taken the cycle after its last
// byte enters the output register. Reset is asynchronous, active low, control only.
module typed_value_to_ascii_formatter (
  input  logic       clk_i,
  input  logic       rst_ni,
  tvaf_in_if.sink    in_i,
  tvaf_out_if.source out_o
);
  import tvaf_pkg::*;

  top_state_e        state_q, state_d;
  cmd_e              cmd_q;
  logic [VAL_W-1:0]  mag_q;
  logic              flag_q, neg_q, lead_q, dot_q, pidx_q;
  logic [DIG_IW-1:0] idx_q;
  logic [2:0]        tidx_q;
  logic              out_valid_q, out_last_q;
  logic [CH_W-1:0]   out_ch_q;

  logic              acc, can_ld, emit, e_last, skip, at_dot;
  logic [CH_W-1:0]   e_ch;
  logic [3:0]        dig, bcd_dig;
  logic [DIG_IW-1:0] min_idx;
  cmd_e              in_cmd;
  logic              flt_go, bcd_go;
  logic [VAL_W-1:0]  flt_mag, bcd_val, int_mag;
  flt_stat_t         flt_st;
  bcd_stat_t         bcd_st;

  assign in_cmd  = cmd_e'(in_i.cmd);
  assign in_i.ready = (state_q == T_IDLE);
  assign acc     = in_i.valid && in_i.ready;
  assign can_ld  = !out_valid_q || out_o.ready;
  assign int_mag = in_i.value[VAL_W-1] ? ('0 - in_i.value) : in_i.value;

  assign flt_go  = acc && (in_cmd == CMD_FLOAT);
  assign bcd_go  = (acc && (in_cmd == CMD_INT)) || ((state_q == T_FLT) && flt_st.done);
  assign bcd_val = (state_q == T_IDLE) ? int_mag : flt_mag;

  tvaf_flt u_flt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (flt_go),
    .bits_i  (in_i.value),
    .mag_o   (flt_mag),
    .stat_o  (flt_st)
  );

  tvaf_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_go),
    .value_i (bcd_val),
    .sel_i   (idx_q),
    .dig_o   (bcd_dig),
    .stat_o  (bcd_st)
  );

  // Digits are walked from the top; leading zeros are skipped without output.
  assign dig     = (cmd_q == CMD_HEX) ? mag_q[{idx_q[3:0], 2'b00} +: 4] : bcd_dig;
  assign min_idx = (cmd_q == CMD_FLOAT) ? DIG_IW'(3) : DIG_IW'(0);
  assign skip    = lead_q && (dig == 4'd0) && (idx_q > min_idx);
  assign at_dot  = (cmd_q == CMD_FLOAT) && (idx_q == DIG_IW'(2)) && !dot_q;

  always_comb begin
    emit   = 1'b0;
    e_ch   = CH_NUL;
    e_last = 1'b0;
    unique case (state_q)
      T_PRE: begin
        emit = can_ld;
        if (cmd_q == CMD_HEX) e_ch = pidx_q ? CH_X : CH_0;
        else                  e_ch = CH_MINUS;
      end
      T_DIG: begin
        emit   = can_ld && !skip;
        e_ch   = at_dot ? CH_DOT : digit_char(dig);
        e_last = !at_dot && (idx_q == '0);
      end
      T_TXT: begin
        emit   = can_ld;
        e_ch   = txt_char(cmd_q, flag_q, tidx_q, mag_q);
        e_last = (tidx_q == txt_last(cmd_q, flag_q));
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (acc) begin
          unique case (in_cmd)
            CMD_FLOAT: state_d = T_FLT;
            CMD_INT:   state_d = T_BCD;
            CMD_HEX:   state_d = T_PRE;
            CMD_NULL, CMD_BOOL, CMD_CHAR, CMD_DELIM, CMD_FLUSH, CMD_RAW:
              state_d = T_TXT;
            default:   state_d = T_IDLE;
          endcase
        end
      end
      T_FLT: if (flt_st.done) state_d = T_BCD;
      T_BCD: if (bcd_st.done) state_d = neg_q ? T_PRE : T_DIG;
      T_PRE: if (emit && ((cmd_q != CMD_HEX) || pidx_q)) state_d = T_DIG;
      T_DIG, T_TXT: if (emit && e_last) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ch_q   <= e_ch;
      out_last_q <= e_last;
    end
    if (acc) begin
      cmd_q  <= in_cmd;
      mag_q  <= in_i.value;
      flag_q <= |in_i.value;
      neg_q  <= in_i.value[VAL_W-1];
      pidx_q <= 1'b0;
      tidx_q <= '0;
      idx_q  <= DIG_IW'(15);
      lead_q <= 1'b1;
      dot_q  <= 1'b0;
    end
    if ((state_q == T_FLT) && flt_st.done) neg_q <= flt_st.neg;
    if ((state_q == T_BCD) && bcd_st.done) begin
      idx_q  <= DIG_IW'(NDIG - 1);
      lead_q <= 1'b1;
      dot_q  <= 1'b0;
    end
    if ((state_q == T_PRE) && emit) pidx_q <= 1'b1;
    if (state_q == T_DIG) begin
      if (skip) begin
        idx_q <= idx_q - DIG_IW'(1);
      end else if (emit) begin
        if (at_dot) begin
          dot_q <= 1'b1;
        end else begin
          lead_q <= 1'b0;
          if (idx_q != '0) idx_q <= idx_q - DIG_IW'(1);
        end
      end
    end
    if ((state_q == T_TXT) && emit) tidx_q <= tidx_q + 3'd1;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.ch    = out_ch_q;
  assign out_o.last  = out_last_q;

  a_bcd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_IDLE) |-> !bcd_st.busy)
    else $error("BCD converter busy while no item is in flight");

  a_flt_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flt_st.done |-> (state_q == T_FLT))
    else $error("float unit finished outside the float wait state");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && e_last) |=> (state_q == T_IDLE) && out_o.last)
    else $error("final byte loaded but item did not end");

  a_hex_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == T_DIG) && (cmd_q == CMD_HEX)) |-> !idx_q[DIG_IW-1])
    else $error("hex digit index out of range");

  a_dot_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == T_DIG) && (cmd_q == CMD_FLOAT) && emit && e_last) |-> dot_q)
    else $error("float ended without a decimal point");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the typed value to ASCII formatter.
`timescale 1ns / 100ps

module tb_top;
  import tvaf_pkg::*;

  typedef struct {
    logic [CH_W-1:0] ch;
    logic            last;
  } text_byte_t;

  class text_scoreboard;
    text_byte_t expected_text[$];
    int         mismatches;

    function automatic void push_char(ref text_byte_t q[$], input logic [CH_W-1:0] c);
      text_byte_t b;
      b.ch   = c;
      b.last = 1'b0;
      q.push_back(b);
    endfunction

    function automatic void push_decimal(ref text_byte_t q[$], input logic [63:0] v);
      logic [CH_W-1:0] digits[$];
      do begin
        digits.push_front(CH_0 + CH_W'(v % 10));
        v = v / 10;
      end while (v != 0);
      foreach (digits[i]) push_char(q, digits[i]);
    endfunction

    // Scale a double by 1000, truncate toward zero and saturate to 64 bits.
    function automatic void push_float(ref text_byte_t q[$], input logic [63:0] bits);
      real         scaled;
      longint      whole;
      logic        neg;
      logic [63:0] mag;
      int unsigned frac;
      neg    = 1'b0;
      scaled = $bitstoreal(bits) * 1000.0;
      if (scaled != scaled) begin
        mag = '0;
      end else if (scaled >= 9223372036854775808.0) begin
        mag = 64'h7fff_ffff_ffff_ffff;
      end else if (scaled < -9223372036854775808.0) begin
        neg = 1'b1;
        mag = 64'h8000_0000_0000_0000;
      end else begin
        // The cast rounds, so step back toward zero where it overshot.
        whole = longint'(scaled);
        if (whole > 0 && real'(whole) > scaled) whole = whole - 1;
        if (whole < 0 && real'(whole) < scaled) whole = whole + 1;
        neg = (whole < 0);
        mag = neg ? 64'(-whole) : 64'(whole);
      end
      if (neg) push_char(q, CH_MINUS);
      push_decimal(q, mag / 1000);
      frac = int'(mag % 1000);
      push_char(q, CH_DOT);
      push_char(q, CH_0 + CH_W'(frac / 100));
      push_char(q, CH_0 + CH_W'((frac / 10) % 10));
      push_char(q, CH_0 + CH_W'(frac % 10));
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value);
      text_byte_t q[$];
      int         sh;
      case (cmd)
        CMD_NULL: begin
          push_char(q, "n"); push_char(q, "u"); push_char(q, "l"); push_char(q, "l");
        end
        CMD_BOOL: begin
          if (value != 0) begin
            push_char(q, "t"); push_char(q, "r"); push_char(q, "u"); push_char(q, "e");
          end else begin
            push_char(q, "f"); push_char(q, "a"); push_char(q, "l"); push_char(q, "s");
            push_char(q, "e");
          end
        end
        CMD_INT: begin
          if (value[63]) begin
            push_char(q, CH_MINUS);
            push_decimal(q, -value);
          end else begin
            push_decimal(q, value);
          end
        end
        CMD_HEX: begin
          push_char(q, CH_0);
          push_char(q, CH_X);
          sh = 60;
          while (sh > 0 && value[sh +: 4] == 4'h0) sh = sh - 4;
          for (int s = sh; s >= 0; s = s - 4) begin
            if (value[s +: 4] < 10) push_char(q, CH_0 + CH_W'(value[s +: 4]));
            else push_char(q, CH_LA + CH_W'(value[s +: 4]) - 8'd10);
          end
        end
        CMD_FLOAT: push_float(q, value);
        CMD_CHAR:  push_char(q, value[7:0]);
        CMD_DELIM: push_char(q, CH_COMMA);
        CMD_FLUSH: begin
          push_char(q, CH_NL);
          push_char(q, CH_NUL);
        end
        CMD_RAW: for (int i = 0; i < 8; i++) push_char(q, value[8*i +: 8]);
        default: ;
      endcase
      if (q.size() > 0) q[q.size()-1].last = 1'b1;
      foreach (q[i]) expected_text.push_back(q[i]);
    endfunction

    function void check_byte(logic [CH_W-1:0] ch, logic last);
      text_byte_t want;
      if (expected_text.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte: ch=%02h last=%0b", ch, last);
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte mismatch: expected ch=%02h last=%0b, got ch=%02h last=%0b",
                   want.ch, want.last, ch, last);
      end
    endfunction

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic quiet = 1'b0;
  int   cycles = 0;
  int   stall_left = 0;

  tvaf_in_if  cmd_if ();
  tvaf_out_if text_if ();
  text_scoreboard sb = new();

  typed_value_to_ascii_formatter dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if.sink),
    .out_o (text_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.cmd   = '0;
    cmd_if.value = '0;
    text_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stalls in random bursts until the quiet tail of the run.
  always @(negedge clk_i) begin
    if (quiet) begin
      text_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      text_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      text_if.ready <= 1'b0;
    end else begin
      text_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && text_if.valid && text_if.ready)
      sb.check_byte(text_if.ch, text_if.last);
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= cmd;
    cmd_if.value <= value;
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
    sb.note_command(cmd, value);
  endtask

  function automatic logic [VAL_W-1:0] wide_random();
    logic [VAL_W-1:0] v;
    v = {$urandom, $urandom};
    return v >> $urandom_range(0, 63);
  endfunction

  function automatic logic [VAL_W-1:0] random_double();
    real r;
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: r = real'(int'($urandom)) / 1000.0;
      2: r = real'(int'($urandom)) * real'($urandom_range(0, 1 << 20));
      default: r = real'(int'($urandom)) / real'($urandom_range(1, 1 << 24));
    endcase
    return $realtobits(r);
  endfunction

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(CMD_NULL, '0);
    send_item(CMD_BOOL, '0);
    send_item(CMD_BOOL, 64'h8000_0000_0000_0000);
    send_item(CMD_INT, '0);
    send_item(CMD_INT, 64'h7fff_ffff_ffff_ffff);
    send_item(CMD_INT, 64'h8000_0000_0000_0000);
    send_item(CMD_INT, '1);
    send_item(CMD_HEX, '0);
    send_item(CMD_HEX, '1);
    send_item(CMD_HEX, 64'h0000_0000_0abc_def0);
    send_item(CMD_FLOAT, 64'h7ff8_0000_0000_0000);
    send_item(CMD_FLOAT, 64'h7ff0_0000_0000_0000);
    send_item(CMD_FLOAT, 64'hfff0_0000_0000_0000);
    send_item(CMD_FLOAT, $realtobits(-0.0));
    send_item(CMD_FLOAT, $realtobits(-0.0005));
    send_item(CMD_FLOAT, $realtobits(-1234.5678));
    send_item(CMD_FLOAT, $realtobits(4.5e9));
    send_item(CMD_FLOAT, $realtobits(-9223372036854775.808));
    send_item(CMD_CHAR, 64'hffff_ffff_ffff_ff80);
    send_item(CMD_DELIM, '1);
    send_item(CMD_FLUSH, '0);
    send_item(CMD_RAW, 64'h0123_4567_89ab_cdef);
    send_item(4'hf, '1);
    send_item(CMD_RAW + 4'd1, '0);

    // Hold off the sender until the formatter has drained completely.
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);

    for (int n = 0; n < 180; n++) begin
      if (n == 150) quiet = 1'b1;
      if ($urandom_range(0, 19) == 0) cmd = CMD_RAW + 4'($urandom_range(1, 7));
      else cmd = 4'($urandom_range(0, 8));
      value = (cmd == CMD_FLOAT) ? random_double() : wide_random();
      if (cmd == CMD_INT && $urandom_range(0, 1) == 0) value = -value;
      send_item(cmd, value);
    end
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
